/* src/isls_pkg.sv */
// ----------------------------------------------------------------------------
// isls_pkg
// Shared types and constants for the indexed shift list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isls_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_W     = 32;

  localparam int REQ_W      = 3;
  localparam int POS_W      = 5;
  localparam int IN_WORD_W  = 32;
  localparam int OUT_WORD_W = 32;
  localparam int FILL_W     = 5;

  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD    = 2'd1,
    CELL_FROM_LO = 2'd2,
    CELL_FROM_HI = 2'd3
  } cell_op_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  fill;
  } res_t;

endpackage

`default_nettype wire

/* src/isls_cell.sv */
// ----------------------------------------------------------------------------
// isls_cell
// One storage cell of the list: holds, loads a new word, or takes the word
// of its lower or upper neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isls_cell (
  input  wire                              clk,
  input  isls_pkg::cell_op_t               op,
  input  wire  [isls_pkg::WORD_W-1:0]      load_word,
  input  wire  [isls_pkg::WORD_W-1:0]      lo_word,
  input  wire  [isls_pkg::WORD_W-1:0]      hi_word,
  output logic [isls_pkg::WORD_W-1:0]      data_q
);
  import isls_pkg::*;

  logic [WORD_W-1:0] data_r;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:    data_r <= data_r;
      CELL_LOAD:    data_r <= load_word;
      CELL_FROM_LO: data_r <= lo_word;
      CELL_FROM_HI: data_r <= hi_word;
    endcase
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

/* src/isls_ctrl.sv */
// ----------------------------------------------------------------------------
// isls_ctrl
// Count register and request decode: per-cell shift commands, status,
// read word and new fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isls_ctrl (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              acc,
  input  wire  [isls_pkg::REQ_W-1:0]       req_type,
  input  wire  [isls_pkg::POS_W-1:0]       position,
  input  wire  [isls_pkg::WORD_W-1:0]      cell_q [isls_pkg::DEPTH],
  output isls_pkg::cell_op_t               cell_op [isls_pkg::DEPTH],
  output isls_pkg::res_t                   res
);
  import isls_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  cell_op_t          op [DEPTH];
  status_t           status;
  logic [WORD_W-1:0] rd_word;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [IDX_W-1:0]  rd_idx;
  logic              full;

  assign pos_c  = CMP_W'(position);
  assign cnt_c  = CMP_W'(count_r);
  assign rd_idx = IDX_W'(position);
  assign full   = (count_r == CNT_W'(DEPTH));

  always_comb begin
    status    = ST_OK;
    rd_word   = '0;
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      op[i] = CELL_HOLD;
    end
    unique case (req_type)
      REQ_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == count_r) op[i] = CELL_LOAD;
          end
        end
      end
      REQ_POP: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (pos_c > cnt_c) begin
          status = ST_BADIDX;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (CMP_W'(i) == pos_c) begin
              op[i] = CELL_LOAD;
            end else if (CMP_W'(i) > pos_c && CMP_W'(i) <= cnt_c) begin
              op[i] = CELL_FROM_LO;
            end
          end
        end
      end
      REQ_REMOVE: begin
        if (pos_c >= cnt_c) begin
          status = ST_BADIDX;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (CMP_W'(i) >= pos_c && CMP_W'(i + 1) < cnt_c) op[i] = CELL_FROM_HI;
          end
        end
      end
      REQ_READ: begin
        if (pos_c >= cnt_c) begin
          status = ST_BADIDX;
        end else begin
          rd_word = cell_q[rd_idx];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = acc ? op[i] : CELL_HOLD;
    end
  end

  assign res.status = status;
  assign res.word   = rd_word;
  assign res.fill   = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r))
    else $error("count changed without a request");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    acc && req_type == REQ_PUSH && status == ST_OK |=>
      count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the count");

  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && status != ST_OK |=> $stable(count_r))
    else $error("refused request changed the count");

endmodule

`default_nettype wire

/* src/indexed_shift_list_store_top.sv */
// ----------------------------------------------------------------------------
// indexed_shift_list_store_top
// Ordered word list with push, pop, insert, remove and read by index.
//
// Input channel in_*: one request per accepted valid/stall handshake,
// carrying req_type, position and word_in. Output channel out_*: one result
// per request with status, word_out and the fill count after the request.
// Each entry lives in its own cell; insert and remove move every affected
// cell to its neighbor's word in the same cycle, and the result is
// registered: throughput is one request per cycle while the receiver does
// not stall. A new request is taken while the output register is
// empty or being taken in the same cycle; while the receiver stalls a held
// result, in_stall is high and the result stays unchanged.
// Reset empties the list and drops any pending result; stored words are
// not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_shift_list_store_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [isls_pkg::REQ_W-1:0]           in_req_type,
  input  wire  [isls_pkg::POS_W-1:0]           in_position,
  input  wire  [isls_pkg::IN_WORD_W-1:0]       in_word_in,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [1:0]                           out_status,
  output logic [isls_pkg::OUT_WORD_W-1:0]      out_word_out,
  output logic [isls_pkg::FILL_W-1:0]          out_fill_count
);
  import isls_pkg::*;

  logic                  acc;
  logic [WORD_W-1:0]     load_word;
  logic [WORD_W-1:0]     cell_q [DEPTH];
  cell_op_t              cell_op [DEPTH];
  res_t                  res;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [OUT_WORD_W-1:0] out_word_r;
  logic [FILL_W-1:0]     out_fill_r;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign load_word = WORD_W'(in_word_in);

  isls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .req_type (in_req_type),
    .position (in_position),
    .cell_q   (cell_q),
    .cell_op  (cell_op),
    .res      (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;

    if (i == 0) begin : g_lo_edge
      assign lo_word = '0;
    end else begin : g_lo
      assign lo_word = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi_edge
      assign hi_word = '0;
    end else begin : g_hi
      assign hi_word = cell_q[i+1];
    end

    isls_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .load_word (load_word),
      .lo_word   (lo_word),
      .hi_word   (hi_word),
      .data_q    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= res.status;
      out_word_r   <= OUT_WORD_W'(res.word);
      out_fill_r   <= FILL_W'(res.fill);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_word_out   = out_word_r;
  assign out_fill_count = out_fill_r;

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted request left no result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fill_count))
    else $error("stalled result lost");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed shift list store. A queue of requests
// (a short directed opening, then phases that grow, shrink and churn the
// list) feeds a valid/stall driver. Each accepted request updates a local
// copy of the list and queues its expected result. A monitor checks every
// result field by field, and both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import isls_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam int RANDOM_REQUESTS = 850;
  localparam int IDLE_PERCENT = 20;
  localparam int QUIET_FROM = 300;
  localparam int QUIET_TO = 450;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 4;

  localparam int PHASE_GROW = 0;
  localparam int PHASE_SHRINK = 1;
  localparam int PHASE_CHURN = 2;

  typedef struct {
    logic [REQ_W-1:0]     kind;
    logic [POS_W-1:0]     pos;
    logic [IN_WORD_W-1:0] word;
  } list_request_t;

  typedef struct {
    status_t               status;
    logic [OUT_WORD_W-1:0] word;
    logic [FILL_W-1:0]     fill;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [IN_WORD_W-1:0] in_word_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [OUT_WORD_W-1:0] out_word_out;
  logic [FILL_W-1:0] out_fill_count;

  list_request_t pending_requests[$];
  list_result_t expected_results[$];
  logic [WORD_W-1:0] list_words[DEPTH];
  int list_count = 0;
  int planned_count = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  indexed_shift_list_store_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_word_in(in_word_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_word_out(out_word_out),
    .out_fill_count(out_fill_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // applies one request to the local list copy and gives its result
  function automatic list_result_t apply_list_request(list_request_t r);
    list_result_t res;
    res.status = ST_OK;
    res.word = '0;
    case (r.kind)
      REQ_PUSH: begin
        if (list_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_count] = r.word[WORD_W-1:0];
          list_count++;
        end
      end
      REQ_POP: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else list_count--;
      end
      REQ_INSERT: begin
        if (r.pos > list_count) begin
          res.status = ST_BADIDX;
        end else if (list_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_count; i > r.pos; i--) list_words[i] = list_words[i-1];
          list_words[r.pos] = r.word[WORD_W-1:0];
          list_count++;
        end
      end
      REQ_REMOVE: begin
        if (r.pos >= list_count) begin
          res.status = ST_BADIDX;
        end else begin
          for (int i = r.pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      REQ_READ: begin
        if (r.pos >= list_count) res.status = ST_BADIDX;
        else res.word = OUT_WORD_W'(list_words[r.pos]);
      end
      default: ;
    endcase
    res.fill = FILL_W'(list_count);
    return res;
  endfunction

  // queues a request and tracks the count it leaves, for steering positions
  task automatic queue_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic [IN_WORD_W-1:0] word);
    list_request_t r;
    r.kind = kind;
    r.pos = pos;
    r.word = word;
    pending_requests.push_back(r);
    case (kind)
      REQ_PUSH: if (planned_count < DEPTH) planned_count++;
      REQ_POP: if (planned_count > 0) planned_count--;
      REQ_INSERT: if (pos <= planned_count && planned_count < DEPTH) planned_count++;
      REQ_REMOVE: if (pos < planned_count) planned_count--;
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_list_request('{in_req_type, in_position, in_word_in}));
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 &&
            ((requests_taken >= QUIET_FROM && requests_taken < QUIET_TO) ||
             $urandom_range(99) >= IDLE_PERCENT)) begin
          in_valid <= 1'b1;
          in_req_type <= pending_requests[0].kind;
          in_position <= pending_requests[0].pos;
          in_word_in <= pending_requests[0].word;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d word %h fill %0d", $time,
                   out_status, out_word_out, out_fill_count);
          mismatches++;
        end else begin
          if (out_status !== expected_results[0].status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     expected_results[0].status, out_status);
            mismatches++;
          end
          if (out_word_out !== expected_results[0].word) begin
            $display("%0t: word_out expected %h actual %h", $time,
                     expected_results[0].word, out_word_out);
            mismatches++;
          end
          if (out_fill_count !== expected_results[0].fill) begin
            $display("%0t: fill_count expected %0d actual %0d", $time,
                     expected_results[0].fill, out_fill_count);
            mismatches++;
          end
          void'(expected_results.pop_front());
        end
        results_seen++;
      end
      out_stall <= !(results_seen >= QUIET_FROM && results_seen < QUIET_TO) &&
                   ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase_kind;
    int phase_left;
    int roll;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    logic [IN_WORD_W-1:0] word;

    // empty list corner cases
    queue_request(REQ_POP, 5'd0, 32'h0);
    queue_request(REQ_REMOVE, 5'd0, 32'h0);
    queue_request(REQ_READ, 5'd0, 32'h0);
    queue_request(REQ_INSERT, 5'd1, 32'hdead_beef);
    // first entries, word extremes, append by insert at the end
    queue_request(REQ_INSERT, 5'd0, 32'hffff_ffff);
    queue_request(REQ_PUSH, 5'd0, 32'h0000_0000);
    queue_request(REQ_PUSH, 5'd31, 32'ha5a5_a5a5);
    queue_request(REQ_INSERT, 5'd3, 32'h5a5a_5a5a);
    queue_request(REQ_INSERT, 5'd1, 32'h1234_5678);
    queue_request(REQ_READ, 5'd0, 32'h0);
    queue_request(REQ_READ, 5'd4, 32'h0);
    queue_request(REQ_READ, 5'd5, 32'h0);
    queue_request(REQ_READ, 5'd31, 32'hffff_ffff);
    // remove last, first, past the end
    queue_request(REQ_REMOVE, 5'd4, 32'h0);
    queue_request(REQ_REMOVE, 5'd0, 32'h0);
    queue_request(REQ_REMOVE, 5'd3, 32'h0);
    // unused codes
    queue_request(REQ_UNUSED_LO, 5'd31, 32'hffff_ffff);
    queue_request(REQ_UNUSED_LO + 3'd1, 5'd0, 32'h0);
    queue_request(REQ_UNUSED_HI, 5'd16, 32'h8000_0001);
    queue_request(REQ_POP, 5'd0, 32'h0);
    queue_request(REQ_READ, 5'd1, 32'h0);
    queue_request(REQ_INSERT, 5'd16, 32'h0);

    // random phases that fill, drain or churn the list
    phase_left = 0;
    phase_kind = PHASE_GROW;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(70, 20);
        phase_kind = $urandom_range(PHASE_CHURN, PHASE_GROW);
      end
      phase_left--;
      roll = $urandom_range(99);
      if (roll < 3) begin
        kind = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
      end else begin
        case (phase_kind)
          PHASE_GROW:
            kind = (roll < 45) ? REQ_PUSH : (roll < 80) ? REQ_INSERT :
                   (roll < 88) ? REQ_POP : (roll < 94) ? REQ_REMOVE : REQ_READ;
          PHASE_SHRINK:
            kind = (roll < 10) ? REQ_PUSH : (roll < 18) ? REQ_INSERT :
                   (roll < 50) ? REQ_POP : (roll < 85) ? REQ_REMOVE : REQ_READ;
          default:
            kind = (roll < 22) ? REQ_PUSH : (roll < 42) ? REQ_INSERT :
                   (roll < 56) ? REQ_POP : (roll < 72) ? REQ_REMOVE : REQ_READ;
        endcase
      end
      if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(31));
      else if (kind == REQ_INSERT) pos = POS_W'($urandom_range(planned_count));
      else if (planned_count > 0) pos = POS_W'($urandom_range(planned_count - 1));
      else pos = '0;
      roll = $urandom_range(9);
      word = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hffff_ffff : $urandom;
      queue_request(kind, pos, word);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/isls_pkg.sv
src/isls_cell.sv
src/isls_ctrl.sv
src/indexed_shift_list_store_top.sv
tb/testbench.sv
